FILE: sv/light_balance_stepper_tracker_core_assert.svh
// Assertion macros shared by the light balance stepper tracker RTL.
`ifndef LIGHT_BALANCE_STEPPER_TRACKER_CORE_ASSERT_SVH
`define LIGHT_BALANCE_STEPPER_TRACKER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbst: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define LBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbst: next-cycle check failed");

`endif

FILE: sv/lbst_pkg.sv
// Shared constants, codes and helpers of the light balance stepper tracker.
package lbst_pkg;

  // Window geometry and calibration.
  localparam int unsigned WINDOW        = 10;
  localparam int unsigned CALIB_DIVISOR = 1;
  localparam int unsigned SAMPLE_BITS   = 12;

  // Fixed field widths.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned OUT_W      = 12;
  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CYCLE_W    = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PIDX_W     = 2;

  // Derived storage widths.
  localparam int unsigned WIN_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = $clog2(WINDOW * ((1 << WIN_W) - 1) + 1);

  // sum / WINDOW as multiply by rounded-up reciprocal (exact for SUM_W-bit sums).
  localparam int unsigned AVG_SH     = SUM_W + $clog2(WINDOW);
  localparam int unsigned AVG_MUL_W  = SUM_W + 1;
  localparam int unsigned AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
    AVG_MUL_W'(((64'd1 << AVG_SH) + WINDOW - 1) / WINDOW);

  // average / CALIB_DIVISOR the same way (exact for OUT_W-bit averages).
  localparam int unsigned LVL_SH     = OUT_W + $clog2(CALIB_DIVISOR);
  localparam int unsigned LVL_MUL_W  = OUT_W + 1;
  localparam int unsigned LVL_PROD_W = LVL_SH + OUT_W + 1;
  localparam logic [LVL_MUL_W-1:0] LVL_MUL =
    LVL_MUL_W'(((64'd1 << LVL_SH) + CALIB_DIVISOR - 1) / CALIB_DIVISOR);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // Sensor channels and move directions.
  localparam logic CH_A      = 1'b0;
  localparam logic DIR_RIGHT = 1'b0;
  localparam logic DIR_LEFT  = 1'b1;

  // Motion sequencer codes.
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SETTLE = 2'd2;

  localparam logic [PIDX_W-1:0] PHASE_FIRST = 2'd0;
  localparam logic [PIDX_W-1:0] PHASE_LAST  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CYCLES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd5;

  // Configuration reset values.
  localparam logic              AUTO_MODE_RST   = 1'b0;
  localparam logic [OUT_W-1:0]  DIFF_THR_RST    = 12'd0;
  localparam logic [OUT_W-1:0]  MAX_LEVEL_RST   = 12'd4095;
  localparam logic [TICK_W-1:0] PHASE_DELAY_RST = 16'd2;
  localparam logic [CYCLE_W-1:0] STEP_CYCLES_RST = 8'd32;
  localparam logic [TICK_W-1:0] SETTLE_RST      = 16'd750;

  localparam logic [PHASE_W-1:0] PAT_PHASE1 = 4'b0001;
  localparam logic [PHASE_W-1:0] PAT_PHASE4 = 4'b1000;

  // One-hot wave drive: right walks phase 1..4, left walks phase 4..1.
  function automatic logic [PHASE_W-1:0] pattern_for(input logic dir,
                                                     input logic [PIDX_W-1:0] idx);
    logic [PHASE_W-1:0] pat;
    if (dir == DIR_LEFT) begin
      pat = PAT_PHASE4 >> idx;
    end else begin
      pat = PAT_PHASE1 << idx;
    end
    return pat;
  endfunction

endpackage

FILE: sv/lbst_item_if.sv
// Input beat channel of the light balance stepper tracker.
interface lbst_item_if;
  logic                             valid;
  logic                             ready;
  logic [lbst_pkg::KIND_W-1:0]      kind;
  logic                             channel;
  logic [lbst_pkg::SLOT_W-1:0]      slot;
  logic [lbst_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output kind, output channel, output slot,
                  output sample, input ready);
  modport sink   (input valid, input kind, input channel, input slot,
                  input sample, output ready);
endinterface

FILE: sv/lbst_res_if.sv
// Result beat channel of the light balance stepper tracker.
interface lbst_res_if;
  logic                           valid;
  logic                           ready;
  logic [lbst_pkg::PHASE_W-1:0]   phase_drive;
  logic [lbst_pkg::OUT_W-1:0]     average_a;
  logic [lbst_pkg::OUT_W-1:0]     average_b;
  logic [lbst_pkg::OUT_W-1:0]     level_a;
  logic [lbst_pkg::OUT_W-1:0]     level_b;
  logic                           busy_res;
  logic                           move_dir;

  modport source (output valid, output phase_drive, output average_a, output average_b,
                  output level_a, output level_b, output busy_res, output move_dir,
                  input ready);
  modport sink   (input valid, input phase_drive, input average_a, input average_b,
                  input level_a, input level_b, input busy_res, input move_dir,
                  output ready);
endinterface

FILE: sv/light_balance_stepper_tracker_core.sv
// Light balance stepper tracker: sensor windows, levels and wave-drive sequencer.
//
// Channels: item_i carries one beat per item (sample write, evaluate or 1 ms
// tick); res_o returns exactly one status beat per item, in order. Both use
// valid/ready; a beat moves when both are high. The cfg_* port writes one
// register per cycle with cfg_we_i high; indexes past the last are dropped.
// Write configuration only while no beat is in flight.
//
// Pipeline: an accepted item is registered in the input stage, and the result
// register loads from that stage on an edge where the pipe advances; the status
// beat then shows on res_o. Throughput: one beat per cycle while res_o is not
// stalled. Two register stages: the input stage (window/sum update plus the
// item kind), then one short pass through the reciprocal multiplies, the level
// compare and the motion sequencer into the result register.
//
// Stall: both stages share one enable; while a result beat waits on res_o.ready
// the pipe freezes and item_i.ready drops, so nothing is lost or repeated.
// Reset: windows and sums clear, coils off, sequencer idle, config registers
// take their defaults, no result beat pending.
`include "light_balance_stepper_tracker_core_assert.svh"

module light_balance_stepper_tracker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lbst_item_if.sink                         item_i,
  lbst_res_if.source                        res_o,
  input  logic                              cfg_we_i,
  input  logic [lbst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbst_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lbst_pkg::*;

  typedef logic [SLOT_W:0] slot_cmp_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic               auto_mode_q;
  logic [OUT_W-1:0]   diff_thr_q;
  logic [OUT_W-1:0]   max_level_q;
  logic [TICK_W-1:0]  phase_delay_q;
  logic [CYCLE_W-1:0] step_cycles_q;
  logic [TICK_W-1:0]  settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_mode_q   <= AUTO_MODE_RST;
      diff_thr_q    <= DIFF_THR_RST;
      max_level_q   <= MAX_LEVEL_RST;
      phase_delay_q <= PHASE_DELAY_RST;
      step_cycles_q <= STEP_CYCLES_RST;
      settle_q      <= SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AUTO_MODE:   auto_mode_q   <= cfg_wdata_i[0];
        CFG_DIFF_THR:    diff_thr_q    <= cfg_wdata_i[OUT_W-1:0];
        CFG_MAX_LEVEL:   max_level_q   <= cfg_wdata_i[OUT_W-1:0];
        CFG_PHASE_DELAY: phase_delay_q <= cfg_wdata_i[TICK_W-1:0];
        CFG_STEP_CYCLES: step_cycles_q <= cfg_wdata_i[CYCLE_W-1:0];
        CFG_SETTLE:      settle_q      <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: one shared enable for every stage
  // ---------------------------------------------------------------------
  logic res_valid_q;
  logic adv;
  logic item_acc;

  assign adv          = !res_valid_q || res_o.ready;
  assign item_i.ready = adv;
  assign item_acc     = item_i.valid && adv;

  // ---------------------------------------------------------------------
  // Stage 1: window replace and running sums
  // ---------------------------------------------------------------------
  logic [WIN_W-1:0] win_a_q [WINDOW];
  logic [WIN_W-1:0] win_b_q [WINDOW];
  logic [SUM_W-1:0] sum_a_q, sum_b_q;
  logic [SUM_W-1:0] sum_a_d, sum_b_d;
  logic [IDX_W-1:0] win_idx;
  logic [WIN_W-1:0] sample_m;
  logic             slot_ok;
  logic             wr_a, wr_b;

  assign slot_ok  = slot_cmp_t'(item_i.slot) < slot_cmp_t'(WINDOW);
  assign win_idx  = item_i.slot[IDX_W-1:0];
  assign sample_m = item_i.sample[WIN_W-1:0];
  assign wr_a     = item_acc && (item_i.kind == KIND_SAMPLE) && slot_ok &&
                    (item_i.channel == CH_A);
  assign wr_b     = item_acc && (item_i.kind == KIND_SAMPLE) && slot_ok &&
                    (item_i.channel != CH_A);

  // Sums never underflow: the removed entry is always part of the sum.
  assign sum_a_d = sum_a_q - SUM_W'(win_a_q[win_idx]) + SUM_W'(sample_m);
  assign sum_b_d = sum_b_q - SUM_W'(win_b_q[win_idx]) + SUM_W'(sample_m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_a_q[i] <= '0;
        win_b_q[i] <= '0;
      end
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      if (wr_a) begin
        win_a_q[win_idx] <= sample_m;
        sum_a_q          <= sum_a_d;
      end
      if (wr_b) begin
        win_b_q[win_idx] <= sample_m;
        sum_b_q          <= sum_b_d;
      end
    end
  end

  // The sum registers double as stage 1 payload: the result stage samples
  // them in the same edge that moves this beat on.
  logic              s1_valid_q;
  logic [KIND_W-1:0] s1_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= item_i.kind;
    end
  end

  // ---------------------------------------------------------------------
  // Averages and calibrated levels (constant reciprocal multiplies)
  // ---------------------------------------------------------------------
  logic [AVG_PROD_W-1:0] avg_prod_a, avg_prod_b;
  logic [LVL_PROD_W-1:0] lvl_prod_a, lvl_prod_b;
  logic [OUT_W-1:0]      avg_a, avg_b, lvl_a, lvl_b;

  assign avg_prod_a = AVG_PROD_W'(sum_a_q) * AVG_PROD_W'(AVG_MUL);
  assign avg_prod_b = AVG_PROD_W'(sum_b_q) * AVG_PROD_W'(AVG_MUL);
  assign avg_a      = OUT_W'(avg_prod_a[AVG_SH +: WIN_W]);
  assign avg_b      = OUT_W'(avg_prod_b[AVG_SH +: WIN_W]);

  assign lvl_prod_a = LVL_PROD_W'(avg_a) * LVL_PROD_W'(LVL_MUL);
  assign lvl_prod_b = LVL_PROD_W'(avg_b) * LVL_PROD_W'(LVL_MUL);
  assign lvl_a      = lvl_prod_a[LVL_SH +: OUT_W];
  assign lvl_b      = lvl_prod_b[LVL_SH +: OUT_W];

  // ---------------------------------------------------------------------
  // Stage 2: motion sequencer and result register
  // ---------------------------------------------------------------------
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic               dir_q, dir_d;
  logic [PIDX_W-1:0]  phase_q, phase_d, phase_inc;
  logic [CYCLE_W-1:0] cycles_q, cycles_d, cycles_dec, step_eff;
  logic [TICK_W-1:0]  tick_q, tick_d, tick_inc, delay_eff;
  logic [PHASE_W-1:0] drive_q, drive_d;
  logic               go_right, go_left;

  assign tick_inc   = tick_q + 1'b1;
  assign phase_inc  = phase_q + 1'b1;
  assign cycles_dec = cycles_q - 1'b1;
  assign delay_eff  = (phase_delay_q == '0) ? TICK_W'(1) : phase_delay_q;
  assign step_eff   = (step_cycles_q == '0) ? CYCLE_W'(1) : step_cycles_q;

  // Brighter side must lead by more than the threshold and not be saturated.
  assign go_right = (lvl_a > lvl_b) &&
                    ((lvl_a - lvl_b) > diff_thr_q) &&
                    (lvl_a < max_level_q);
  assign go_left  = (lvl_b > lvl_a) &&
                    ((lvl_b - lvl_a) > diff_thr_q) &&
                    (lvl_b < max_level_q);

  always_comb begin
    mode_d   = mode_q;
    dir_d    = dir_q;
    phase_d  = phase_q;
    cycles_d = cycles_q;
    tick_d   = tick_q;
    drive_d  = drive_q;
    unique case (s1_kind_q)
      KIND_EVAL: begin
        if (auto_mode_q && (mode_q == MODE_IDLE) && (go_right || go_left)) begin
          dir_d    = go_right ? DIR_RIGHT : DIR_LEFT;
          phase_d  = PHASE_FIRST;
          cycles_d = step_eff;
          tick_d   = '0;
          drive_d  = pattern_for(go_right ? DIR_RIGHT : DIR_LEFT, PHASE_FIRST);
          mode_d   = MODE_MOVE;
        end
      end
      KIND_TICK: begin
        unique case (mode_q)
          MODE_MOVE: begin
            if (tick_inc >= delay_eff) begin
              tick_d = '0;
              if (phase_q == PHASE_LAST) begin
                cycles_d = cycles_dec;
                if (cycles_dec == '0) begin
                  // Move done: last pattern stays on the coils.
                  mode_d = (settle_q == '0) ? MODE_IDLE : MODE_SETTLE;
                end else begin
                  phase_d = PHASE_FIRST;
                  drive_d = pattern_for(dir_q, PHASE_FIRST);
                end
              end else begin
                phase_d = phase_inc;
                drive_d = pattern_for(dir_q, phase_inc);
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          MODE_SETTLE: begin
            if (tick_inc >= settle_q) begin
              tick_d = '0;
              mode_d = MODE_IDLE;
            end else begin
              tick_d = tick_inc;
            end
          end
          MODE_IDLE: ;
          default: ;
        endcase
      end
      KIND_SAMPLE: ;
      default: ;
    endcase
  end

  logic             seq_en;
  logic [OUT_W-1:0] res_avg_a_q, res_avg_b_q, res_lvl_a_q, res_lvl_b_q;

  assign seq_en = adv && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      dir_q       <= DIR_RIGHT;
      phase_q     <= PHASE_FIRST;
      cycles_q    <= '0;
      tick_q      <= '0;
      drive_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        res_valid_q <= s1_valid_q;
      end
      if (seq_en) begin
        mode_q   <= mode_d;
        dir_q    <= dir_d;
        phase_q  <= phase_d;
        cycles_q <= cycles_d;
        tick_q   <= tick_d;
        drive_q  <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_en) begin
      res_avg_a_q <= avg_a;
      res_avg_b_q <= avg_b;
      res_lvl_a_q <= lvl_a;
      res_lvl_b_q <= lvl_b;
    end
  end

  // Sequencer state only moves with a result beat, so it is the status.
  assign res_o.valid       = res_valid_q;
  assign res_o.phase_drive = drive_q;
  assign res_o.average_a   = res_avg_a_q;
  assign res_o.average_b   = res_avg_b_q;
  assign res_o.level_a     = res_lvl_a_q;
  assign res_o.level_b     = res_lvl_b_q;
  assign res_o.busy_res    = (mode_q != MODE_IDLE);
  assign res_o.move_dir    = dir_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `LBST_ASSERT_SAME(a_drive_onehot, clk_i, rst_ni, 1'b1, $onehot0(drive_q))
  `LBST_ASSERT_SAME(a_idle_tick_clear, clk_i, rst_ni, mode_q == MODE_IDLE, tick_q == '0)
  `LBST_ASSERT_SAME(a_move_has_cycles, clk_i, rst_ni, mode_q == MODE_MOVE, cycles_q != '0)
  `LBST_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni, res_valid_q && !res_o.ready, !item_i.ready)
  `LBST_ASSERT_NEXT(a_accept_enters_pipe, clk_i, rst_ni, item_acc, s1_valid_q)

endmodule

FILE: sim/lbst_tracker_check.sv
// Status checker for the light balance tracker: mirrors its state, predicts and compares.
`timescale 1ns / 1ps

module lbst_tracker_check
  import lbst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lbst_item_if                  item_i,
  lbst_res_if                   res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           checked_o,
  output int unsigned           right_moves_o,
  output int unsigned           left_moves_o,
  output int unsigned           backlog_o
);

  typedef struct packed {
    logic [PHASE_W-1:0] phase_drive;
    logic [OUT_W-1:0]   average_a;
    logic [OUT_W-1:0]   average_b;
    logic [OUT_W-1:0]   level_a;
    logic [OUT_W-1:0]   level_b;
    logic               busy;
    logic               move_dir;
  } status_t;

  // mirrored tracker state
  logic [OUT_W-1:0]   win_a [WINDOW];
  logic [OUT_W-1:0]   win_b [WINDOW];
  logic [TICK_W-1:0]  sum_a, sum_b;
  logic [PHASE_W-1:0] coils;
  logic [MODE_W-1:0]  seq_mode;
  logic               dir_q;
  logic [PIDX_W-1:0]  step_idx;
  logic [CYCLE_W-1:0] cycles_q;
  logic [TICK_W-1:0]  ticks_q;

  // mirrored registers
  logic               cfg_auto;
  logic [OUT_W-1:0]   cfg_thr, cfg_max;
  logic [TICK_W-1:0]  cfg_delay, cfg_settle;
  logic [CYCLE_W-1:0] cfg_steps;

  status_t pending_status [$];
  int unsigned n_fail, n_checked, n_right, n_left;

  assign fail_count_o  = n_fail;
  assign checked_o     = n_checked;
  assign right_moves_o = n_right;
  assign left_moves_o  = n_left;

  function automatic logic [PHASE_W-1:0] coil_for(logic dir, logic [PIDX_W-1:0] idx);
    logic [PHASE_W-1:0] walk;
    walk = PHASE_W'(1) << idx;
    return (dir == DIR_LEFT) ? {walk[0], walk[1], walk[2], walk[3]} : walk;
  endfunction

  function automatic void reset_tracker();
    for (int i = 0; i < WINDOW; i++) begin
      win_a[i] = '0;
      win_b[i] = '0;
    end
    sum_a      = '0;
    sum_b      = '0;
    coils      = '0;
    seq_mode   = MODE_IDLE;
    dir_q      = DIR_RIGHT;
    step_idx   = PHASE_FIRST;
    cycles_q   = '0;
    ticks_q    = '0;
    cfg_auto   = AUTO_MODE_RST;
    cfg_thr    = DIFF_THR_RST;
    cfg_max    = MAX_LEVEL_RST;
    cfg_delay  = PHASE_DELAY_RST;
    cfg_steps  = STEP_CYCLES_RST;
    cfg_settle = SETTLE_RST;
  endfunction

  function automatic void begin_move(logic dir);
    dir_q    = dir;
    step_idx = PHASE_FIRST;
    cycles_q = (cfg_steps == '0) ? CYCLE_W'(1) : cfg_steps;
    ticks_q  = '0;
    coils    = coil_for(dir, PHASE_FIRST);
    seq_mode = MODE_MOVE;
    if (dir == DIR_LEFT) n_left++;
    else n_right++;
  endfunction

  // One item through the tracker; returns the status beat it should produce.
  function automatic status_t step_tracker(logic [KIND_W-1:0] kind, logic ch,
                                           logic [SLOT_W-1:0] slot,
                                           logic [SAMPLE_W-1:0] smp);
    status_t           st;
    logic [OUT_W-1:0]  avg_a, avg_b, lvl_a, lvl_b;
    logic [TICK_W-1:0] hold;
    if (kind == KIND_SAMPLE && slot < WINDOW) begin
      if (ch == CH_A) begin
        sum_a       = sum_a - TICK_W'(win_a[slot]) + TICK_W'(smp);
        win_a[slot] = smp;
      end else begin
        sum_b       = sum_b - TICK_W'(win_b[slot]) + TICK_W'(smp);
        win_b[slot] = smp;
      end
    end
    avg_a = OUT_W'(sum_a / WINDOW);
    avg_b = OUT_W'(sum_b / WINDOW);
    lvl_a = OUT_W'(avg_a / CALIB_DIVISOR);
    lvl_b = OUT_W'(avg_b / CALIB_DIVISOR);

    if (kind == KIND_EVAL) begin
      if (cfg_auto && seq_mode == MODE_IDLE) begin
        if (lvl_a > lvl_b && (lvl_a - lvl_b) > cfg_thr && lvl_a < cfg_max) begin
          begin_move(DIR_RIGHT);
        end else if (lvl_b > lvl_a && (lvl_b - lvl_a) > cfg_thr && lvl_b < cfg_max) begin
          begin_move(DIR_LEFT);
        end
      end
    end else if (kind == KIND_TICK) begin
      hold = (cfg_delay == '0) ? TICK_W'(1) : cfg_delay;
      if (seq_mode == MODE_MOVE) begin
        ticks_q++;
        if (ticks_q >= hold) begin
          ticks_q = '0;
          if (step_idx == PHASE_LAST) begin
            cycles_q--;
            if (cycles_q == '0) begin
              seq_mode = (cfg_settle == '0) ? MODE_IDLE : MODE_SETTLE;
            end else begin
              step_idx = PHASE_FIRST;
              coils    = coil_for(dir_q, PHASE_FIRST);
            end
          end else begin
            step_idx++;
            coils = coil_for(dir_q, step_idx);
          end
        end
      end else if (seq_mode == MODE_SETTLE) begin
        ticks_q++;
        if (ticks_q >= cfg_settle) begin
          ticks_q  = '0;
          seq_mode = MODE_IDLE;
        end
      end
    end

    st.phase_drive = coils;
    st.average_a   = avg_a;
    st.average_b   = avg_b;
    st.level_a     = lvl_a;
    st.level_b     = lvl_b;
    st.busy        = (seq_mode != MODE_IDLE);
    st.move_dir    = dir_q;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want, got;
    if (!rst_ni) begin
      reset_tracker();
      pending_status.delete();
      n_fail    = 0;
      n_checked = 0;
      n_right   = 0;
      n_left    = 0;
      backlog_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AUTO_MODE:   cfg_auto   = cfg_wdata_i[0];
          CFG_DIFF_THR:    cfg_thr    = cfg_wdata_i[OUT_W-1:0];
          CFG_MAX_LEVEL:   cfg_max    = cfg_wdata_i[OUT_W-1:0];
          CFG_PHASE_DELAY: cfg_delay  = cfg_wdata_i;
          CFG_STEP_CYCLES: cfg_steps  = cfg_wdata_i[CYCLE_W-1:0];
          CFG_SETTLE:      cfg_settle = cfg_wdata_i;
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        pending_status.push_back(step_tracker(item_i.kind, item_i.channel,
                                              item_i.slot, item_i.sample));
      end
      if (res_i.valid && res_i.ready) begin
        got = {res_i.phase_drive, res_i.average_a, res_i.average_b, res_i.level_a,
               res_i.level_b, res_i.busy_res, res_i.move_dir};
        if (pending_status.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("[%0t] status beat with no prediction pending", $time);
        end else begin
          want = pending_status.pop_front();
          n_checked++;
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] status mismatch: want drive=%b avg=%0d/%0d lvl=%0d/%0d busy=%b dir=%b",
                       $time, want.phase_drive, want.average_a, want.average_b,
                       want.level_a, want.level_b, want.busy, want.move_dir);
              $display("            got  drive=%b avg=%0d/%0d lvl=%0d/%0d busy=%b dir=%b",
                       got.phase_drive, got.average_a, got.average_b,
                       got.level_a, got.level_b, got.busy, got.move_dir);
            end
          end
        end
      end
      backlog_o <= pending_status.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the light balance stepper tracker: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
  import lbst_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES   = 8;    // well past the 2-stage pipe
  localparam int unsigned HOLD_AT_A      = 160;  // item beats seen before a long stall
  localparam int unsigned HOLD_AT_B      = 500;
  localparam int unsigned HOLD_CYCLES    = 300;

  // codes the package leaves unnamed
  localparam logic [KIND_W-1:0]    KIND_SPARE     = 2'd3;
  localparam logic                 CH_B           = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 3'd7;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count, checked, right_moves, left_moves, backlog;
  int unsigned burst_left, n_beats, n_configs;
  logic        bright_ch;

  lbst_item_if item_ch();
  lbst_res_if  res_ch();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  light_balance_stepper_tracker_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lbst_tracker_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_ch),
    .res_i         (res_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .checked_o     (checked),
    .right_moves_o (right_moves),
    .left_moves_o  (left_moves),
    .backlog_o     (backlog)
  );

  // Offer one item beat and wait for it to be taken. The sender runs in bursts;
  // at the start of each new burst it drops valid for a random gap. Now and then
  // a burst is long, giving stretches with no idling at all.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic ch,
                           input logic [SLOT_W-1:0] slot, input logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    item_ch.valid   <= 1'b1;
    item_ch.kind    <= kind;
    item_ch.channel <= ch;
    item_ch.slot    <= slot;
    item_ch.sample  <= smp;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    burst_left--;
    n_beats++;
  endtask

  // Stop offering, wait for every predicted status beat, then let the pipe empty.
  task automatic drain_pipe();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; we is lowered for a cycle so back-to-back calls stay clean.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic auto_on, input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] max_lvl,
                              input logic [CFG_DATA_W-1:0] delay,
                              input logic [CFG_DATA_W-1:0] steps,
                              input logic [CFG_DATA_W-1:0] settle);
    drain_pipe();
    write_reg(CFG_AUTO_MODE,   CFG_DATA_W'(auto_on));
    write_reg(CFG_DIFF_THR,    thr);
    write_reg(CFG_MAX_LEVEL,   max_lvl);
    write_reg(CFG_PHASE_DELAY, delay);
    write_reg(CFG_STEP_CYCLES, steps);
    write_reg(CFG_SETTLE,      settle);
    n_configs++;
  endtask

  // Random traffic. Samples lean toward one bright sensor (which flips now and
  // then) so the levels pull apart and evaluations actually start moves; ticks
  // walk the moves through their phases and settle time.
  task automatic random_items(input int unsigned count, input int unsigned tick_pct);
    int unsigned pick;
    logic        ch;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] smp;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) bright_ch = ~bright_ch;
      pick = $urandom_range(0, 99);
      ch   = 1'($urandom_range(0, 1));
      slot = SLOT_W'($urandom_range(0, 15));
      smp  = SAMPLE_W'($urandom_range(0, 4095));
      if (pick < tick_pct) begin
        send_beat(KIND_TICK, ch, slot, smp);
      end else if (pick < tick_pct + 12) begin
        send_beat(KIND_EVAL, ch, slot, smp);
      end else if (pick < tick_pct + 14) begin
        send_beat(KIND_SPARE, ch, slot, smp);
      end else begin
        // mostly in-window slots, the odd write past the end
        if ($urandom_range(0, 15) != 0) slot = SLOT_W'($urandom_range(0, WINDOW - 1));
        if ($urandom_range(0, 4) != 0) begin
          smp = (ch == bright_ch) ? SAMPLE_W'($urandom_range(2500, 4095))
                                  : SAMPLE_W'($urandom_range(0, 1200));
        end
        send_beat(KIND_SAMPLE, ch, slot, smp);
      end
    end
  endtask

  // Receiver pacing: a random style, redrawn when its run ends, plus two long
  // hold-offs keyed to the number of item beats taken, so the pipe backs up
  // and the block must drop item ready.
  initial begin : rx_pace
    int unsigned beats_in, hold_left, style_left, beat_phase;
    rx_style_e   style;
    beats_in   = 0;
    hold_left  = 0;
    style_left = 0;
    beat_phase = 0;
    style      = RX_OPEN;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (item_ch.valid && item_ch.ready) begin
        beats_in++;
        if (beats_in == HOLD_AT_A || beats_in == HOLD_AT_B) hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      beat_phase++;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (style)
          RX_OPEN:  res_ch.ready <= 1'b1;
          RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: res_ch.ready <= ($urandom_range(0, 9) < 3);
          default:  res_ch.ready <= (beat_phase % 5 != 4);
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.kind    = KIND_SAMPLE;
    item_ch.channel = CH_A;
    item_ch.slot    = '0;
    item_ch.sample  = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_AUTO_MODE;
    cfg_wdata       = '0;
    burst_left      = 0;
    n_beats         = 0;
    n_configs       = 0;
    bright_ch       = CH_A;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset settings, auto off ---
    send_beat(KIND_SAMPLE, CH_A, 4'd0, 12'hFFF);    // full-scale sample
    send_beat(KIND_SAMPLE, CH_A, 4'd9, 12'hFFF);    // last slot
    send_beat(KIND_SAMPLE, CH_B, 4'd5, 12'hAAA);
    send_beat(KIND_SAMPLE, CH_B, 4'd8, 12'h555);
    send_beat(KIND_SAMPLE, CH_A, 4'd10, 12'hFFF);   // past the window: dropped
    send_beat(KIND_SAMPLE, CH_B, 4'd15, 12'hFFF);   // likewise
    send_beat(KIND_EVAL, CH_A, 4'd0, 12'h000);      // auto off: no move
    send_beat(KIND_TICK, CH_B, 4'd3, 12'h123);      // tick while idle
    send_beat(KIND_SPARE, CH_B, 4'd7, 12'hFFF);     // unused kind, status only

    // fastest move: one tick per phase, one cycle, no settle
    apply_config(1'b1, 16'd0, 16'd4095, 16'd1, 16'd1, 16'd0);
    write_reg(CFG_UNUSED_LO, 16'hFFFF);             // out-of-range indexes: no effect
    write_reg(CFG_UNUSED_HI, 16'h5A5A);
    send_beat(KIND_EVAL, CH_A, 4'd0, 12'h000);      // A brighter: right move
    send_beat(KIND_EVAL, CH_B, 4'd0, 12'h000);      // evaluate while busy
    repeat (4) send_beat(KIND_TICK, CH_A, 4'd0, 12'h000);
    send_beat(KIND_SAMPLE, CH_B, 4'd0, 12'hFFF);
    send_beat(KIND_SAMPLE, CH_B, 4'd1, 12'hFFF);
    send_beat(KIND_EVAL, CH_A, 4'd0, 12'h000);      // B brighter: left move
    repeat (4) send_beat(KIND_TICK, CH_A, 4'd0, 12'h000);
    send_beat(KIND_SAMPLE, CH_A, 4'd0, 12'h000);

    // --- random phases over a spread of register settings ---
    random_items(90, 30);
    apply_config(1'b1, CFG_DATA_W'($urandom_range(0, 300)),
                 CFG_DATA_W'($urandom_range(1500, 4095)),
                 CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                 CFG_DATA_W'($urandom_range(0, 6)));
    random_items(90, 35);
    // threshold written with junk high bits: masks to 4095, nothing may move
    apply_config(1'b1, 16'hFFFF, 16'd0, 16'd2, 16'd2, 16'd2);
    random_items(50, 30);
    // longest phase hold: a move parks on its first pattern
    apply_config(1'b1, 16'd0, 16'd4095, 16'hFFFF, 16'd1, 16'd2);
    random_items(40, 40);
    // parked move finishes, then the longest settle
    apply_config(1'b1, 16'd0, 16'd4095, 16'd2, 16'd2, 16'hFFFF);
    random_items(50, 50);
    // zero delay and zero cycles both act as one
    apply_config(1'b1, 16'd20, 16'd4000, 16'd0, 16'd0, 16'd3);
    random_items(90, 35);
    apply_config(1'b0, 16'd0, 16'd4095, 16'd1, 16'd1, 16'd1);
    random_items(40, 35);
    repeat (2) begin
      apply_config(1'b1, CFG_DATA_W'($urandom_range(0, 300)),
                   CFG_DATA_W'($urandom_range(1500, 4095)),
                   CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                   CFG_DATA_W'($urandom_range(0, 6)));
      random_items(80, 35);
    end

    // most cycles per move; tick-heavy so a long move runs well into its count
    apply_config(1'b1, 16'd0, 16'd4095, 16'd0, 16'd255, 16'd1);
    for (int s = 0; s < WINDOW; s++) begin
      send_beat(KIND_SAMPLE, CH_A, SLOT_W'(s), 12'd4000);
      send_beat(KIND_SAMPLE, CH_B, SLOT_W'(s), 12'd0);
    end
    send_beat(KIND_EVAL, CH_A, 4'd0, 12'h000);
    random_items(230, 85);

    drain_pipe();
    $display("Run covered %0d item beats across %0d register settings; %0d status beats checked.",
             n_beats, n_configs, checked);
    $display("Moves started: %0d right, %0d left.", right_moves, left_moves);
    if (fail_count == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
